// ===== hdl/sha1_message_hasher_macros.svh =====
// Assertion macros shared by the hasher RTL.
`ifndef SHA1_MESSAGE_HASHER_MACROS_SVH
`define SHA1_MESSAGE_HASHER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sha1_pkg.sv =====
// Types, constants and round functions of the SHA-1 hasher.
`timescale 1ns / 1ps

package sha1_pkg;

   localparam int WORD_W       = 32;
   localparam int DIGEST_WORDS = 5;
   localparam int BLOCK_WORDS  = 16;
   localparam int ROUNDS       = 80;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [DIGEST_WORDS-1:0][WORD_W-1:0] hash_type;
   typedef logic [6:0] round_type;

   localparam word_type K0 = 32'h5A827999;
   localparam word_type K1 = 32'h6ED9EBA1;
   localparam word_type K2 = 32'h8F1BBCDC;
   localparam word_type K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam hash_type INIT_HASH = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

   // Boolean function of the round group.
   function automatic word_type round_f(round_type rnd, word_type b, word_type c,
                                        word_type d);
      word_type f;
      case (rnd) inside
         [7'd0:7'd19]:  f = (b & c) | (~b & d);
         [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
         default:       f = b ^ c ^ d;
      endcase
      return f;
   endfunction

   // Additive constant of the round group.
   function automatic word_type round_k(round_type rnd);
      word_type k;
      case (rnd) inside
         [7'd0:7'd19]:  k = K0;
         [7'd20:7'd39]: k = K1;
         [7'd40:7'd59]: k = K2;
         default:       k = K3;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/sha1_message_hasher.sv =====
// SHA-1 message hasher: word intake, padding, iterative compression and digest output.
`timescale 1ns / 1ps
`include "sha1_message_hasher_macros.svh"

// The block hashes a message that arrives one big-endian 32-bit word per transfer, first
// byte in bits 31 to 24. Every word but the last is taken as four full bytes; the word
// flagged by req_final_word carries 0 to 4 valid high-order bytes (values above 4 count
// as 4, and 0 marks an empty tail). A plain word is taken without a stall, except that the
// sixteenth word of each 64-byte block starts a compression: 80 rounds on a single round
// datapath followed by a fold step that folds the working variables into the chaining
// value; no further word is taken until that compression is done. After the final word
// the block appends the 0x80 byte, zero fill and the 64-bit bit length one word per
// cycle outside of compressions, running one or two more of them, and then offers the
// five digest words on the rsp_ channel, word_index 0 (most significant) first, with
// digest_last on the fifth. req_stall is high while a compression runs, and from the
// start of the padding until the fifth digest transfer, after which the chaining value
// is back at the initial constants and the next message may begin.
module sha1_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_bytes_valid,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_digest_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_PAD   = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   localparam sha1_pkg::round_type LAST_ROUND = 7'(sha1_pkg::ROUNDS - 1);
   localparam sha1_pkg::round_type FOLD_STEP  = 7'(sha1_pkg::ROUNDS);
   localparam logic [3:0] FILL_LAST  = 4'(sha1_pkg::BLOCK_WORDS - 1);
   localparam logic [3:0] FILL_LEN   = 4'(sha1_pkg::BLOCK_WORDS - 2);
   localparam logic [2:0] INDEX_LAST = 3'(sha1_pkg::DIGEST_WORDS - 1);
   localparam sha1_pkg::word_type PAD_FIRST = {sha1_pkg::PAD_BYTE, 24'd0};

   logic [1:0]              state_ff, state_in;
   sha1_pkg::hash_type      chain_ff, chain_in;
   sha1_pkg::hash_type      vars_ff, vars_in;
   sha1_pkg::word_type      sched_ff [sha1_pkg::BLOCK_WORDS];
   logic [3:0]              fill_ff, fill_in;
   logic [63:0]             bits_ff, bits_in;
   sha1_pkg::round_type     round_ff, round_in;
   logic [2:0]              index_ff, index_in;
   logic                    finishing_ff, finishing_in;
   logic                    pad_pend_ff, pad_pend_in;
   logic                    hi_done_ff, hi_done_in;
   logic                    len_done_ff, len_done_in;

   // Shift line control for the message schedule.
   logic                    shift_en;
   sha1_pkg::word_type      shift_word;
   logic                    do_push;
   sha1_pkg::word_type      push_word;

   logic [2:0]              n_sat;
   sha1_pkg::word_type      tail_word;
   sha1_pkg::word_type      sched_next;
   sha1_pkg::word_type      t_sum;
   sha1_pkg::hash_type      vars_step;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_ff[index_ff];
   assign rsp_word_index  = index_ff;
   assign rsp_digest_last = (index_ff == INDEX_LAST);

   // The byte count saturates at four.
   always_comb begin
      case (req_bytes_valid) inside
         [3'd4:3'd7]: n_sat = 3'd4;
         default:     n_sat = req_bytes_valid;
      endcase
   end

   // The last partial word keeps its valid bytes and takes the pad byte right after them.
   always_comb begin
      case (n_sat)
         3'd1:    tail_word = {req_data_word[31:24], sha1_pkg::PAD_BYTE, 16'd0};
         3'd2:    tail_word = {req_data_word[31:16], sha1_pkg::PAD_BYTE, 8'd0};
         3'd3:    tail_word = {req_data_word[31:8], sha1_pkg::PAD_BYTE};
         default: tail_word = PAD_FIRST;
      endcase
   end

   // One SHA-1 round. The schedule word for this round always sits at the head of the
   // shift line, and the word sixteen rounds ahead is formed from fixed taps.
   always_comb begin
      sha1_pkg::word_type x;
      x          = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      sched_next = {x[30:0], x[31]};
      t_sum      = {vars_ff[0][26:0], vars_ff[0][31:27]}
                 + sha1_pkg::round_f(round_ff, vars_ff[1], vars_ff[2], vars_ff[3])
                 + vars_ff[4] + sha1_pkg::round_k(round_ff) + sched_ff[0];
      vars_step[0] = t_sum;
      vars_step[1] = vars_ff[0];
      vars_step[2] = {vars_ff[1][1:0], vars_ff[1][31:2]};
      vars_step[3] = vars_ff[2];
      vars_step[4] = vars_ff[3];
   end

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      vars_in      = vars_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      round_in     = round_ff;
      index_in     = index_ff;
      finishing_in = finishing_ff;
      pad_pend_in  = pad_pend_ff;
      hi_done_in   = hi_done_ff;
      len_done_in  = len_done_ff;
      shift_en     = 1'b0;
      shift_word   = sched_next;
      do_push      = 1'b0;
      push_word    = req_data_word;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               do_push = 1'b1;
               if (!req_final_word) begin
                  bits_in = bits_ff + 64'd32;
               end else begin
                  bits_in      = bits_ff + {58'd0, n_sat, 3'b000};
                  finishing_in = 1'b1;
                  hi_done_in   = 1'b0;
                  len_done_in  = 1'b0;
                  state_in     = ST_PAD;
                  if (n_sat == 3'd4) begin
                     pad_pend_in = 1'b1;
                  end else begin
                     pad_pend_in = 1'b0;
                     push_word   = tail_word;
                  end
               end
            end
         end
         ST_PAD: begin
            do_push = 1'b1;
            if (pad_pend_ff) begin
               push_word   = PAD_FIRST;
               pad_pend_in = 1'b0;
            end else if (hi_done_ff) begin
               push_word   = bits_ff[31:0];
               len_done_in = 1'b1;
            end else if (fill_ff == FILL_LEN) begin
               push_word  = bits_ff[63:32];
               hi_done_in = 1'b1;
            end else begin
               push_word = '0;
            end
         end
         ST_ROUND: begin
            if (round_ff == FOLD_STEP) begin
               round_in = '0;
               for (int k = 0; k < sha1_pkg::DIGEST_WORDS; k++) begin
                  chain_in[k] = chain_ff[k] + vars_ff[k];
               end
               if (!finishing_ff) begin
                  state_in = ST_IDLE;
               end else if (len_done_ff) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_PAD;
               end
            end else begin
               shift_en = 1'b1;
               vars_in  = vars_step;
               round_in = round_ff + 7'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (index_ff == INDEX_LAST) begin
                  index_in     = '0;
                  chain_in     = sha1_pkg::INIT_HASH;
                  fill_in      = '0;
                  bits_in      = '0;
                  finishing_in = 1'b0;
                  len_done_in  = 1'b0;
                  hi_done_in   = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A pushed word enters the shift line; the sixteenth one starts a compression.
      if (do_push) begin
         shift_en   = 1'b1;
         shift_word = push_word;
         fill_in    = fill_ff + 4'd1;
         if (fill_ff == FILL_LAST) begin
            vars_in  = chain_ff;
            round_in = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= sha1_pkg::INIT_HASH;
         vars_ff      <= '0;
         fill_ff      <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         index_ff     <= '0;
         finishing_ff <= 1'b0;
         pad_pend_ff  <= 1'b0;
         hi_done_ff   <= 1'b0;
         len_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         vars_ff      <= vars_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         round_ff     <= round_in;
         index_ff     <= index_in;
         finishing_ff <= finishing_in;
         pad_pend_ff  <= pad_pend_in;
         hi_done_ff   <= hi_done_in;
         len_done_ff  <= len_done_in;
      end
   end

   // Message schedule shift line; the head is the word of the current round.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < sha1_pkg::BLOCK_WORDS - 1; i++) begin
            sched_ff[i] <= sched_ff[i+1];
         end
         sched_ff[sha1_pkg::BLOCK_WORDS-1] <= shift_word;
      end
   end

   `SHA1_ASSERT_NOW(a_round_range, (state_ff == ST_ROUND), (round_ff <= FOLD_STEP), "round counter past fold step")
   `SHA1_ASSERT_NOW(a_out_quiet, (state_ff == ST_OUT), (round_ff == '0 && fill_ff == '0 && len_done_ff), "digest offered before padding completed")
   `SHA1_ASSERT_NEXT(a_block_start, (state_ff == ST_ROUND && round_ff == LAST_ROUND), (fill_ff == '0 && round_ff == FOLD_STEP), "compression not aligned to block")
   `SHA1_ASSERT_NEXT(a_msg_restart, (rsp_valid && !rsp_stall && rsp_digest_last), (state_ff == ST_IDLE && bits_ff == '0 && chain_ff == sha1_pkg::INIT_HASH), "hasher not restored after digest")

endmodule
